### rtl/tfpd_pkg.sv
// ----------------------------------------------------------------------------
// tfpd_pkg
// Shared types and constants for the touch frame pen event decoder.
// ----------------------------------------------------------------------------
package tfpd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned EVENT_W = 2;
    localparam int unsigned OUT_TDATA_W = 24;

    localparam logic [BYTE_W-1:0] HDR0_BYTE = 8'hBB;
    localparam logic [BYTE_W-1:0] HDR1_BYTE = 8'hCC;
    localparam logic [BYTE_W-1:0] HDR2_BYTE = 8'h02;
    localparam logic [BYTE_W-1:0] KEY_MARK  = 8'hEE;
    localparam logic [BYTE_W-1:0] TOUCH_ON  = 8'h01;

    // Position of the next byte within a frame
    typedef enum logic [2:0] {
        POS_HDR0  = 3'd0,
        POS_HDR1  = 3'd1,
        POS_HDR2  = 3'd2,
        POS_X     = 3'd3,
        POS_Y     = 3'd4,
        POS_TOUCH = 3'd5,
        POS_CHECK = 3'd6
    } t_frame_pos;

    typedef enum logic [EVENT_W-1:0] {
        EV_DRAG = 2'd0,
        EV_DOWN = 2'd1,
        EV_UP   = 2'd2
    } t_pen_event;

    // Frame that passed its checksum, valid for one cycle
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] y;
        logic [BYTE_W-1:0] touch;
    } t_frame;

    typedef struct packed {
        t_pen_event        pen_event;
        logic [BYTE_W-1:0] pos_x;
        logic [BYTE_W-1:0] pos_y;
    } t_result;

endpackage

### rtl/tfpd_parser.sv
// ----------------------------------------------------------------------------
// tfpd_parser
// Tracks the frame position and running checksum, captures the payload and
// flags a frame whose checksum byte matches.
// ----------------------------------------------------------------------------
module tfpd_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [tfpd_pkg::BYTE_W-1:0] i_byte,
    output tfpd_pkg::t_frame            o_frame
);
    import tfpd_pkg::*;

    t_frame_pos        r_pos,   n_pos;
    logic [BYTE_W-1:0] r_sum,   n_sum;
    logic [BYTE_W-1:0] r_x,     n_x;
    logic [BYTE_W-1:0] r_y,     n_y;
    logic [BYTE_W-1:0] r_touch, n_touch;
    logic [BYTE_W-1:0] sum_add;

    assign sum_add = r_sum + i_byte;

    always_comb begin
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_x     = r_x;
        n_y     = r_y;
        n_touch = r_touch;
        o_frame = '{valid: 1'b0, x: r_x, y: r_y, touch: r_touch};
        if (i_accept) begin
            case (r_pos)
                POS_HDR0: begin
                    // a header miss is not retried as a frame start
                    if (i_byte == HDR0_BYTE) begin
                        n_sum = i_byte;
                        n_pos = POS_HDR1;
                    end else begin
                        n_pos = POS_HDR0;
                    end
                end
                POS_HDR1: begin
                    n_sum = sum_add;
                    n_pos = (i_byte == HDR1_BYTE) ? POS_HDR2 : POS_HDR0;
                end
                POS_HDR2: begin
                    n_sum = sum_add;
                    n_pos = (i_byte == HDR2_BYTE) ? POS_X : POS_HDR0;
                end
                POS_X: begin
                    n_x   = i_byte;
                    n_sum = sum_add;
                    n_pos = POS_Y;
                end
                POS_Y: begin
                    n_y   = i_byte;
                    n_sum = sum_add;
                    n_pos = POS_TOUCH;
                end
                POS_TOUCH: begin
                    n_touch = i_byte;
                    n_sum   = sum_add;
                    n_pos   = POS_CHECK;
                end
                POS_CHECK: begin
                    o_frame.valid = (i_byte == r_sum);
                    n_pos         = POS_HDR0;
                end
                default: begin
                    n_pos = POS_HDR0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_HDR0;
            r_sum   <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_touch <= '0;
        end else begin
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_x     <= n_x;
            r_y     <= n_y;
            r_touch <= n_touch;
        end
    end

endmodule

### rtl/tfpd_judge.sv
// ----------------------------------------------------------------------------
// tfpd_judge
// Compares a checked frame with the last stored position and touch state,
// updates them and decides the pen event.
// ----------------------------------------------------------------------------
module tfpd_judge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tfpd_pkg::t_frame  i_frame,
    output logic              o_valid,
    output tfpd_pkg::t_result o_result
);
    import tfpd_pkg::*;

    logic [BYTE_W-1:0] r_last_x,     n_last_x;
    logic [BYTE_W-1:0] r_last_y,     n_last_y;
    logic [BYTE_W-1:0] r_last_touch, n_last_touch;
    logic              is_key;
    logic              pos_diff;
    logic              touch_diff;
    logic              touch_on;
    logic              drag;

    assign is_key     = (i_frame.x == KEY_MARK);
    assign pos_diff   = (i_frame.x != r_last_x) || (i_frame.y != r_last_y);
    assign touch_diff = (i_frame.touch != r_last_touch);
    assign touch_on   = (i_frame.touch == TOUCH_ON);
    assign drag       = pos_diff && !touch_diff && touch_on;

    always_comb begin
        n_last_x     = r_last_x;
        n_last_y     = r_last_y;
        n_last_touch = r_last_touch;
        o_valid      = 1'b0;
        // key reports leave every stored value alone
        if (i_frame.valid && !is_key) begin
            n_last_x     = i_frame.x;
            n_last_y     = i_frame.y;
            n_last_touch = i_frame.touch;
            o_valid      = drag || touch_diff;
        end
        o_result.pen_event = touch_diff ? (touch_on ? EV_DOWN : EV_UP) : EV_DRAG;
        o_result.pos_x     = n_last_x;
        o_result.pos_y     = n_last_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_last_touch <= '0;
        end else begin
            r_last_x     <= n_last_x;
            r_last_y     <= n_last_y;
            r_last_touch <= n_last_touch;
        end
    end

`ifndef SYNTHESIS
    a_key_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_frame.valid && is_key) |-> !o_valid)
        else $error("key report produced an event");
    a_no_frame_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_frame.valid |=> ($stable(r_last_x) && $stable(r_last_y) && $stable(r_last_touch)))
        else $error("stored values changed without a frame");
    a_event_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.pen_event == EV_DRAG) |-> (i_frame.touch == TOUCH_ON))
        else $error("drag reported with touch released");
`endif

endmodule

### rtl/tfpd_out_buf.sv
// ----------------------------------------------------------------------------
// tfpd_out_buf
// Result register with a skid stage so the input side stays open while a
// result waits on the output.
// ----------------------------------------------------------------------------
module tfpd_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tfpd_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_valid,
    output tfpd_pkg::t_result o_result,
    output logic              o_room
);
    import tfpd_pkg::*;

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main,       n_main;
    t_result r_skid,       n_skid;
    logic    pop;

    assign pop      = r_main_valid && i_ready;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;
    assign o_room   = !r_skid_valid;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (!r_main_valid || pop) begin
            // advance the skid entry first, otherwise load the new result
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_main       = i_result;
                n_main_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

`ifndef SYNTHESIS
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held with empty result register");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("result pushed while buffer full");
    a_skid_to_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && pop) |=> (r_main_valid && r_main == $past(r_skid)))
        else $error("skid entry lost on drain");
`endif

endmodule

### rtl/touch_frame_pen_event_decoder_top.sv
// ----------------------------------------------------------------------------
// touch_frame_pen_event_decoder_top
// Decodes 7-byte touch frames from a byte stream into pen events.
// ----------------------------------------------------------------------------
// Output path: a result decoded from the accepted checksum byte is loaded
//   into the result register, or into the skid entry while the output stalls.
// Throughput: one byte per cycle unless stalled; the two-entry result buffer
//   (result register plus skid) drops o_s_tready under output back-pressure.
// Reset: synchronous, active low; clears the frame position, checksum,
//   payload, stored x/y/touch and the valid flags of both result entries.
// ----------------------------------------------------------------------------
module touch_frame_pen_event_decoder_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [tfpd_pkg::BYTE_W-1:0]      i_s_tdata,   // [7:0] rx_byte
    // master side
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [tfpd_pkg::OUT_TDATA_W-1:0] o_m_tdata    // [1:0] pen_event,
                                                          // [9:2] pos_x,
                                                          // [17:10] pos_y,
                                                          // [23:18] zero
);
    import tfpd_pkg::*;

    logic    accept;
    t_frame  frame;
    logic    res_valid;
    t_result res;
    t_result out_res;

    // A byte transaction moves whenever the skid stage is free; each byte
    // yields at most one result, so two buffer entries never overflow.
    assign accept = i_s_tvalid && o_s_tready;

    // Framing: header match, payload capture and checksum compare.
    tfpd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_byte  (i_s_tdata),
        .o_frame (frame)
    );

    // Event decision against the last stored position and touch state.
    tfpd_judge u_judge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame),
        .o_valid (res_valid),
        .o_result(res)
    );

    // Result register and skid stage toward the master side.
    tfpd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_result(res),
        .i_ready (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_result(out_res),
        .o_room  (o_s_tready)
    );

    // Pack the result: event in the low bits, then x, then y.
    assign o_m_tdata = {6'd0, out_res.pos_y, out_res.pos_x, out_res.pen_event};

endmodule

### tb/touch_frame_pen_event_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// touch_frame_pen_event_decoder_top_tb
// Self-checking bench for the touch frame pen event decoder. Feeds a byte
// stream of well-formed, corrupted and truncated frames plus line noise,
// tracks the frame parser and the stored pen state alongside the block, and
// compares every pen event transaction against the predicted one. The byte
// source and the event sink idle and stall at random, in several phases.
// ----------------------------------------------------------------------------
module touch_frame_pen_event_decoder_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tfpd_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned STALL_BURST    = 400;

    // Sum of the three header bytes, modulo 256
    localparam logic [BYTE_W-1:0] HDR_SUM = HDR0_BYTE + HDR1_BYTE + HDR2_BYTE;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [BYTE_W-1:0]      i_s_tdata  = '0;    // [7:0] rx_byte
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;          // [1:0] pen_event, [9:2] pos_x,
                                                // [17:10] pos_y, [23:18] zero

    touch_frame_pen_event_decoder_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    logic [BYTE_W-1:0] rx_bytes_pending[$];   // bytes waiting to be offered
    t_result           pen_events_due[$];     // predicted pen events, oldest first

    int unsigned src_idle_pct     = 0;
    int unsigned snk_stall_pct    = 0;
    int unsigned stall_burst_left = 0;        // long sink hold-off, in cycles
    int unsigned n_fail           = 0;
    int unsigned quiet_cycles     = 0;
    bit          rx_taken         = 1'b0;     // byte transaction at the last edge

    // Shadow of the frame parser and the stored pen state
    t_frame_pos        trk_pos        = POS_HDR0;
    logic [BYTE_W-1:0] trk_sum        = '0;
    logic [BYTE_W-1:0] trk_x          = '0;
    logic [BYTE_W-1:0] trk_y          = '0;
    logic [BYTE_W-1:0] trk_touch      = '0;
    logic [BYTE_W-1:0] pen_last_x     = '0;
    logic [BYTE_W-1:0] pen_last_y     = '0;
    logic [BYTE_W-1:0] pen_last_touch = '0;

    // ------------------------------------------------------------------------
    // Pen event predictor: advance the parser by one byte and, on a frame
    // with a good checksum, queue the pen event it raises (if any).
    // ------------------------------------------------------------------------
    task automatic track_rx_byte(input logic [BYTE_W-1:0] b);
        t_result ev;
        bit      raised;
        raised       = 1'b0;
        ev.pen_event = EV_DRAG;
        case (trk_pos)
            POS_HDR0: begin
                if (b == HDR0_BYTE) begin
                    trk_sum = b;
                    trk_pos = POS_HDR1;
                end else begin
                    trk_pos = POS_HDR0;
                end
            end
            POS_HDR1: begin
                if (b == HDR1_BYTE) begin
                    trk_sum = trk_sum + b;
                    trk_pos = POS_HDR2;
                end else begin
                    // drop the byte, do not retry it as a frame start
                    trk_pos = POS_HDR0;
                end
            end
            POS_HDR2: begin
                if (b == HDR2_BYTE) begin
                    trk_sum = trk_sum + b;
                    trk_pos = POS_X;
                end else begin
                    trk_pos = POS_HDR0;
                end
            end
            POS_X: begin
                trk_x   = b;
                trk_sum = trk_sum + b;
                trk_pos = POS_Y;
            end
            POS_Y: begin
                trk_y   = b;
                trk_sum = trk_sum + b;
                trk_pos = POS_TOUCH;
            end
            POS_TOUCH: begin
                trk_touch = b;
                trk_sum   = trk_sum + b;
                trk_pos   = POS_CHECK;
            end
            POS_CHECK: begin
                trk_pos = POS_HDR0;
                // key reports and bad checksums leave the pen state alone
                if (b == trk_sum && trk_x != KEY_MARK) begin
                    if (trk_x != pen_last_x || trk_y != pen_last_y) begin
                        pen_last_x = trk_x;
                        pen_last_y = trk_y;
                        if (pen_last_touch == trk_touch && trk_touch == TOUCH_ON) begin
                            ev.pen_event = EV_DRAG;
                            raised       = 1'b1;
                        end
                    end
                    // a touch change overrides a drag
                    if (pen_last_touch != trk_touch) begin
                        pen_last_touch = trk_touch;
                        ev.pen_event   = (trk_touch == TOUCH_ON) ? EV_DOWN : EV_UP;
                        raised         = 1'b1;
                    end
                    if (raised) begin
                        ev.pos_x = pen_last_x;
                        ev.pos_y = pen_last_y;
                        pen_events_due.push_back(ev);
                    end
                end
            end
            default: trk_pos = POS_HDR0;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Byte source: change at the falling edge, hold a byte until it is taken.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || rx_taken) begin
            if (rx_bytes_pending.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= rx_bytes_pending.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
                i_s_tdata  <= 8'($urandom);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Event sink: random stalls, plus a long hold-off when one is requested.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_burst_left != 0) begin
            stall_burst_left <= stall_burst_left - 1;
            i_m_tready       <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and scoreboard: sample both sides at the rising edge. Predict
    // first so that a result can never overtake its own expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        rx_taken = i_rst_n && i_s_tvalid && o_s_tready;
        if (rx_taken) begin
            track_rx_byte(i_s_tdata);
        end

        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pen_events_due.size() == 0) begin
                $error("unexpected pen event transaction, tdata=%h", o_m_tdata);
                n_fail++;
            end else begin
                want = pen_events_due.pop_front();
                if (o_m_tdata[1:0] !== want.pen_event) begin
                    $error("pen_event: expected %0d, actual %0d",
                           want.pen_event, o_m_tdata[1:0]);
                    n_fail++;
                end
                if (o_m_tdata[9:2] !== want.pos_x) begin
                    $error("pos_x: expected %h, actual %h", want.pos_x, o_m_tdata[9:2]);
                    n_fail++;
                end
                if (o_m_tdata[17:10] !== want.pos_y) begin
                    $error("pos_y: expected %h, actual %h", want.pos_y, o_m_tdata[17:10]);
                    n_fail++;
                end
                if (o_m_tdata[23:18] !== '0) begin
                    $error("pad: expected 0, actual %h", o_m_tdata[23:18]);
                    n_fail++;
                end
            end
        end

        // Watchdog: count cycles in which neither side completes a transaction
        if (rx_taken || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push_frame(input logic [BYTE_W-1:0] x, input logic [BYTE_W-1:0] y,
                              input logic [BYTE_W-1:0] t, input bit corrupt);
        logic [BYTE_W-1:0] sum;
        sum = HDR_SUM + x + y + t;
        if (corrupt) begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        rx_bytes_pending.push_back(HDR0_BYTE);
        rx_bytes_pending.push_back(HDR1_BYTE);
        rx_bytes_pending.push_back(HDR2_BYTE);
        rx_bytes_pending.push_back(x);
        rx_bytes_pending.push_back(y);
        rx_bytes_pending.push_back(t);
        rx_bytes_pending.push_back(sum);
    endtask

    // Favor a few repeating values so that drags and no-change frames occur
    function automatic logic [BYTE_W-1:0] pick_coord();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 8'($urandom_range(0, 3));
        if (r < 60) return (r[0]) ? 8'hFF : 8'h00;
        if (r < 68) return KEY_MARK;
        return 8'($urandom);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_touch();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return TOUCH_ON;
        if (r < 85) return 8'h00;
        return 8'($urandom);
    endfunction

    // Hold the source until the stream is consumed and every event is back
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (rx_bytes_pending.size() != 0 || i_s_tvalid || pen_events_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int unsigned src_pct, input int unsigned snk_pct,
                                    input int unsigned n_frames);
        int unsigned r;
        int unsigned k;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (int i = 0; i < n_frames; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                push_frame(pick_coord(), pick_coord(), pick_touch(), 1'b0);
            end else if (r < 80) begin
                push_frame(pick_coord(), pick_coord(), pick_touch(), 1'b1);
            end else if (r < 90) begin
                // truncated frame: a frame prefix cut short by a random byte
                k = $urandom_range(1, 5);
                push_frame(pick_coord(), pick_coord(), pick_touch(), 1'b0);
                repeat (7 - k) void'(rx_bytes_pending.pop_back());
                rx_bytes_pending.push_back(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 4)) rx_bytes_pending.push_back(8'($urandom));
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: pen down, drag, no change, pen up on a non-one touch,
        // key report, bad checksum, broken headers, field extremes.
        push_frame(8'h00, 8'h00, TOUCH_ON, 1'b0);
        push_frame(8'hFF, 8'hFF, TOUCH_ON, 1'b0);
        push_frame(8'hFF, 8'hFF, TOUCH_ON, 1'b0);
        push_frame(8'h10, 8'h20, 8'hFF, 1'b0);
        push_frame(KEY_MARK, 8'h55, TOUCH_ON, 1'b0);
        push_frame(8'h30, 8'h40, TOUCH_ON, 1'b1);
        // second start byte is dropped, not retried, so this frame is lost
        rx_bytes_pending.push_back(HDR0_BYTE);
        push_frame(8'h30, 8'h40, TOUCH_ON, 1'b0);
        rx_bytes_pending.push_back(HDR0_BYTE);
        rx_bytes_pending.push_back(HDR1_BYTE);
        rx_bytes_pending.push_back(8'h03);
        push_frame(8'hAA, 8'h55, TOUCH_ON, 1'b0);
        wait_drained();

        run_random_phase(0, 0, 10);
        run_random_phase(85, 0, 10);
        run_random_phase(0, 85, 10);
        run_random_phase(29, 29, 10);

        // Back-pressure: hold the sink off while the source keeps offering
        // frames that each raise an event, so the block fills and stalls.
        src_idle_pct     = 0;
        snk_stall_pct    = 0;
        stall_burst_left = STALL_BURST;
        for (int i = 0; i < 8; i++) begin
            push_frame(8'h40, 8'h41, (i[0]) ? 8'h00 : TOUCH_ON, 1'b0);
        end
        wait_drained();

        run_random_phase(0, 0, 8);

        if (n_fail == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
